// ----- rtl/bptm_pkg.sv -----
`default_nettype none

package bptm_pkg;

   localparam int ADDR_W = 24;
   localparam int KIND_W = 3;

   localparam logic [1:0] CMD_CHECK  = 2'd0;
   localparam logic [1:0] CMD_ADD    = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;
   localparam logic [1:0] CMD_CLEAR  = 2'd3;

   localparam logic [KIND_W-1:0] KIND_EXEC  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_READ  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_WRITE = 3'd2;
   localparam logic [KIND_W-1:0] KIND_IRQ   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_BRK   = 3'd4;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [KIND_W-1:0] kind;
   } entry_type;

   typedef struct packed {
      logic [7:0]  program_bank;
      logic [15:0] program_counter;
      logic [7:0]  bus_bank;
      logic [15:0] bus_addr;
      logic        data_valid;
      logic        read_not_write;
      logic        in_irq_state;
      logic [7:0]  instr_opcode;
   } cpu_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_SHIFT = 4'b0100,
      ST_PLACE = 4'b1000
   } seq_state_type;

endpackage

`default_nettype wire

// ----- rtl/bptm_ram.sv -----
`default_nettype none

module bptm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/bptm_match.sv -----
`default_nettype none

module bptm_match
   import bptm_pkg::*;
(
   input  wire entry_type    entry,
   input  wire cpu_type      cpu,
   input  wire logic [7:0]   brk_opcode,
   output logic              match
);

   logic [7:0]  bank;
   logic [15:0] lo;
   logic        bus_eq;

   always_comb begin
      bank   = entry.addr[23:16];
      lo     = entry.addr[15:0];
      bus_eq = (cpu.bus_bank == bank) && (cpu.bus_addr == lo);
      case (entry.kind)
         KIND_EXEC: begin
            match = (cpu.program_bank == bank) && (cpu.program_counter == lo);
         end
         KIND_READ: begin
            match = bus_eq && cpu.data_valid && cpu.read_not_write;
         end
         KIND_WRITE: begin
            match = bus_eq && cpu.data_valid && !cpu.read_not_write;
         end
         KIND_IRQ: begin
            match = cpu.in_irq_state;
         end
         KIND_BRK: begin
            match = (cpu.instr_opcode == brk_opcode);
         end
         default: begin
            match = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/debug_breakpoint_table_matcher.sv -----
`default_nettype none

// Breakpoint table matcher.
// A command word is taken when start is high and busy is low. cmd selects
// check (find the lowest table entry that matches the CPU state fields),
// add (sorted insert of bp_address/bp_kind), remove (by entry_index) or clear.
// Every command gives exactly one result word: rsp_strobe is high for one
// cycle with rsp_ok, rsp_hit, rsp_hit_index and rsp_entry_count valid. The
// receiver cannot stall; a result is simply shown for that single cycle.
// csr_wr_en/csr_wr_data write the BRK opcode register; the user is to write
// it only while the block is idle, which the block itself does not enforce.
// Entries live in a single-port-write, single-port-read RAM with registered
// read; all work goes through that RAM, one entry per cycle. Clear, a bad
// remove index and a bad add kind answer without touching the RAM. Check
// reads entries from index 0 up to the first hit or the end. Add runs the
// same search, which ends at a duplicate (table unchanged), at the first
// entry with a greater address, or past the end; it then moves the entries
// from there on up one place, top first, writes the new entry and answers.
// Remove moves the entries above entry_index down one place. A full table
// fails at the end of the search. busy drops as the result shows, so the
// next word can be taken at the edge that ends the result cycle. Reset
// empties the table and clears the BRK opcode; no clearing pass.

module debug_breakpoint_table_matcher
   import bptm_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [23:0] req_bp_address,
   input  wire logic [2:0]  req_bp_kind,
   input  wire logic [9:0]  req_entry_index,
   input  wire logic [7:0]  req_program_bank,
   input  wire logic [15:0] req_program_counter,
   input  wire logic [7:0]  req_bus_bank,
   input  wire logic [15:0] req_bus_addr,
   input  wire logic        req_data_valid,
   input  wire logic        req_read_not_write,
   input  wire logic        req_in_irq_state,
   input  wire logic [7:0]  req_instr_opcode,
   input  wire logic        csr_wr_en,
   input  wire logic [7:0]  csr_wr_data,
   output logic             rsp_strobe,
   output logic             rsp_ok,
   output logic             rsp_hit,
   output logic [9:0]       rsp_hit_index,
   output logic [10:0]      rsp_entry_count
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int EW = $bits(entry_type);

   seq_state_type  state_ff, state_in;
   logic [1:0]     cmd_ff, cmd_in;
   entry_type      new_entry_ff, new_entry_in;
   cpu_type        cpu_ff, cpu_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [CW-1:0]  pos_ff, pos_in;
   logic [CW-1:0]  left_ff, left_in;
   logic [IW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [IW-1:0]  cmp_ptr_ff, cmp_ptr_in;
   logic           rd_valid_ff, rd_valid_in;
   logic           shift_up_ff, shift_up_in;
   logic [7:0]     brk_ff;
   logic           rsp_strobe_ff, rsp_strobe_in;
   logic           rsp_ok_ff, rsp_ok_in;
   logic           rsp_hit_ff, rsp_hit_in;
   logic [9:0]     rsp_hit_index_ff, rsp_hit_index_in;

   logic           wr_en;
   logic [IW-1:0]  wr_addr;
   logic [EW-1:0]  wr_data;
   logic           rd_en;
   logic [EW-1:0]  rd_data;
   entry_type      rd_entry;
   logic           match;
   logic           ins_req;
   logic [CW-1:0]  ins_pos;

   assign rd_entry = entry_type'(rd_data);

   bptm_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_data)
   );

   bptm_match u_match (
      .entry      (rd_entry),
      .cpu        (cpu_ff),
      .brk_opcode (brk_ff),
      .match      (match)
   );

   always_comb begin
      state_in         = state_ff;
      cmd_in           = cmd_ff;
      new_entry_in     = new_entry_ff;
      cpu_in           = cpu_ff;
      count_in         = count_ff;
      pos_in           = pos_ff;
      left_in          = left_ff;
      rd_ptr_in        = rd_ptr_ff;
      cmp_ptr_in       = cmp_ptr_ff;
      rd_valid_in      = 1'b0;
      shift_up_in      = shift_up_ff;
      rsp_strobe_in    = 1'b0;
      rsp_ok_in        = rsp_ok_ff;
      rsp_hit_in       = rsp_hit_ff;
      rsp_hit_index_in = rsp_hit_index_ff;
      wr_en            = 1'b0;
      wr_addr          = '0;
      wr_data          = new_entry_ff;
      rd_en            = 1'b0;
      ins_req          = 1'b0;
      ins_pos          = count_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in       = req_cmd;
               new_entry_in = '{addr: req_bp_address, kind: req_bp_kind};
               cpu_in       = '{program_bank:    req_program_bank,
                                program_counter: req_program_counter,
                                bus_bank:        req_bus_bank,
                                bus_addr:        req_bus_addr,
                                data_valid:      req_data_valid,
                                read_not_write:  req_read_not_write,
                                in_irq_state:    req_in_irq_state,
                                instr_opcode:    req_instr_opcode};
               rsp_hit_in       = 1'b0;
               rsp_hit_index_in = '0;
               case (req_cmd)
                  CMD_CHECK: begin
                     rd_ptr_in = '0;
                     left_in   = count_ff;
                     state_in  = ST_SCAN;
                  end
                  CMD_ADD: begin
                     if (req_bp_kind > KIND_BRK) begin
                        rsp_strobe_in = 1'b1;
                        rsp_ok_in     = 1'b0;
                     end else begin
                        rd_ptr_in = '0;
                        left_in   = count_ff;
                        state_in  = ST_SCAN;
                     end
                  end
                  CMD_REMOVE: begin
                     if ({1'b0, req_entry_index} >= 11'(count_ff)) begin
                        rsp_strobe_in = 1'b1;
                        rsp_ok_in     = 1'b0;
                     end else begin
                        shift_up_in = 1'b0;
                        rd_ptr_in   = IW'(req_entry_index) + IW'(1);
                        left_in     = count_ff - CW'(req_entry_index) - CW'(1);
                        state_in    = ST_SHIFT;
                     end
                  end
                  default: begin
                     count_in      = '0;
                     rsp_strobe_in = 1'b1;
                     rsp_ok_in     = 1'b1;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            if (rd_valid_ff) begin
               if (cmd_ff == CMD_CHECK) begin
                  if (match) begin
                     rsp_strobe_in    = 1'b1;
                     rsp_ok_in        = 1'b1;
                     rsp_hit_in       = 1'b1;
                     rsp_hit_index_in = 10'(cmp_ptr_ff);
                     state_in         = ST_IDLE;
                  end
               end else if (rd_entry.addr > new_entry_ff.addr) begin
                  ins_req = 1'b1;
                  ins_pos = CW'(cmp_ptr_ff);
               end else if (rd_entry == new_entry_ff) begin
                  // duplicate: leave the table as it is
                  rsp_strobe_in = 1'b1;
                  rsp_ok_in     = 1'b1;
                  state_in      = ST_IDLE;
               end
            end else if (left_ff == '0) begin
               if (cmd_ff == CMD_CHECK) begin
                  rsp_strobe_in = 1'b1;
                  rsp_ok_in     = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  ins_req = 1'b1;
                  ins_pos = count_ff;
               end
            end

            if (ins_req) begin
               if (count_ff == CW'(DEPTH)) begin
                  rsp_strobe_in = 1'b1;
                  rsp_ok_in     = 1'b0;
                  state_in      = ST_IDLE;
               end else begin
                  pos_in      = ins_pos;
                  shift_up_in = 1'b1;
                  rd_ptr_in   = IW'(count_ff - CW'(1));
                  left_in     = count_ff - ins_pos;
                  state_in    = ST_SHIFT;
               end
            end else if (state_in == ST_SCAN && left_ff != '0) begin
               rd_en       = 1'b1;
               cmp_ptr_in  = rd_ptr_ff;
               rd_valid_in = 1'b1;
               rd_ptr_in   = rd_ptr_ff + IW'(1);
               left_in     = left_ff - CW'(1);
            end
         end

         ST_SHIFT: begin
            // write back the word read last cycle one place up or down
            if (rd_valid_ff) begin
               wr_en   = 1'b1;
               wr_addr = shift_up_ff ? cmp_ptr_ff + IW'(1) : cmp_ptr_ff - IW'(1);
               wr_data = rd_data;
            end
            if (left_ff != '0) begin
               rd_en       = 1'b1;
               cmp_ptr_in  = rd_ptr_ff;
               rd_valid_in = 1'b1;
               rd_ptr_in   = shift_up_ff ? rd_ptr_ff - IW'(1) : rd_ptr_ff + IW'(1);
               left_in     = left_ff - CW'(1);
            end else if (!rd_valid_ff) begin
               if (shift_up_ff) begin
                  state_in = ST_PLACE;
               end else begin
                  count_in      = count_ff - CW'(1);
                  rsp_strobe_in = 1'b1;
                  rsp_ok_in     = 1'b1;
                  state_in      = ST_IDLE;
               end
            end
         end

         ST_PLACE: begin
            wr_en         = 1'b1;
            wr_addr       = IW'(pos_ff);
            wr_data       = new_entry_ff;
            count_in      = count_ff + CW'(1);
            rsp_strobe_in = 1'b1;
            rsp_ok_in     = 1'b1;
            state_in      = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rd_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         brk_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rd_valid_ff   <= rd_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_wr_en) begin
            brk_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff           <= cmd_in;
      new_entry_ff     <= new_entry_in;
      cpu_ff           <= cpu_in;
      pos_ff           <= pos_in;
      left_ff          <= left_in;
      rd_ptr_ff        <= rd_ptr_in;
      cmp_ptr_ff       <= cmp_ptr_in;
      shift_up_ff      <= shift_up_in;
      rsp_ok_ff        <= rsp_ok_in;
      rsp_hit_ff       <= rsp_hit_in;
      rsp_hit_index_ff <= rsp_hit_index_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_hit_index   = rsp_hit_index_ff;
   assign rsp_entry_count = 11'(count_ff);

endmodule

`default_nettype wire
